/* hdl/emb3_pkg.sv */
// package for the 3x3 emboss convolution core
// holds the register indexes and the eight fixed emboss kernels
// no dependencies
package emb3_pkg;

  typedef logic signed [1:0] coef_t;
  typedef logic [23:0]       pixel_t;

  // configuration register indexes
  localparam logic REG_KERNEL_SELECT = 1'b0;
  localparam logic REG_PADDED_WIDTH  = 1'b1;

  localparam logic [11:0] PADDED_WIDTH_RESET = 12'd642;

  // entry a*3+b weights the pixel of row age a and column age b
  localparam coef_t EMB_KERNEL [8][9] = '{
    '{-2'sd1, 2'sd0,  2'sd0, 2'sd0, 2'sd0, 2'sd0,  2'sd0, 2'sd0,  2'sd1},
    '{ 2'sd1, 2'sd0,  2'sd0, 2'sd0, 2'sd0, 2'sd0,  2'sd0, 2'sd0, -2'sd1},
    '{ 2'sd0, 2'sd0, -2'sd1, 2'sd0, 2'sd0, 2'sd0,  2'sd1, 2'sd0,  2'sd0},
    '{ 2'sd0, 2'sd0,  2'sd1, 2'sd0, 2'sd0, 2'sd0, -2'sd1, 2'sd0,  2'sd0},
    '{-2'sd1, 2'sd0, -2'sd1, 2'sd0, 2'sd0, 2'sd0,  2'sd1, 2'sd0,  2'sd1},
    '{-2'sd1, 2'sd0,  2'sd1, 2'sd0, 2'sd0, 2'sd0,  2'sd1, 2'sd0, -2'sd1},
    '{ 2'sd1, 2'sd0,  2'sd1, 2'sd0, 2'sd0, 2'sd0, -2'sd1, 2'sd0, -2'sd1},
    '{ 2'sd1, 2'sd0, -2'sd1, 2'sd0, 2'sd0, 2'sd0, -2'sd1, 2'sd0,  2'sd1}
  };

endpackage

/* hdl/emboss_3x3_convolution_core.sv */
// 3x3 emboss convolution core: line store memory, window registers and kernel datapath
// depends on emb3_pkg
//
// usage:
//   input words arrive on the s_axis group, one padded rgb pixel each in raster order;
//   tuser marks the first pixel of a frame and restarts row and column counts.
//   result words leave on the m_axis group, tlast marking the last result of a row.
//   no result is given until a full 3x3 window exists (column and row both >= 2).
//   the two previous rows live in one synchronous line store memory, {upper, middle}
//   per column, read when a word is accepted and written back when that word leaves stage 1;
//   a same-column access in the next word is served by forwarding.
// throughput and result path:
//   one word per cycle unless the receiver stalls; a result passes from the stage 1 registers
//   into the output register, the rate being set by one line store read-modify-write
// reset and stall:
//   reset clears counters, window, config and output valid; the line store holds no
//   reset value and is filled by the first two rows of each frame.
//   when the receiver stalls, the output register holds its word and the pixel in
//   flight waits; s_axis_tready drops only if that pixel has a result to deliver.
// config is written through cfg_we_i / cfg_idx_i / cfg_wdata_i while idle.
module emboss_3x3_convolution_core
  import emb3_pkg::*;
#(
  parameter int MAX_WIDTH = 2048
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [11:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // fields from bit 0: pixel_red, pixel_green, pixel_blue
  input  logic [23:0] s_axis_tdata,
  // fields from bit 0: start_of_frame
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // fields from bit 0: out_red, out_green, out_blue
  output logic [23:0] m_axis_tdata,
  output logic        m_axis_tlast
);

  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int EW = (AW + 1 > 12) ? AW + 1 : 12;

  // configuration
  logic [2:0]  kernel_sel_q;
  logic [11:0] padded_width_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kernel_sel_q   <= 3'd0;
      padded_width_q <= PADDED_WIDTH_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_KERNEL_SELECT: kernel_sel_q   <= cfg_wdata_i[2:0];
        REG_PADDED_WIDTH:  padded_width_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  logic [EW-1:0] width_eff;
  always_comb begin
    if (padded_width_q < 12'd3) begin
      width_eff = EW'(3);
    end else if (EW'(padded_width_q) > EW'(MAX_WIDTH)) begin
      width_eff = EW'(MAX_WIDTH);
    end else begin
      width_eff = EW'(padded_width_q);
    end
  end

  // handshake and stage 1 control
  logic          s1_valid_q, s1_prod_q, s1_last_q;
  logic [AW-1:0] s1_addr_q;
  pixel_t        s1_cur_q;
  logic          out_valid_q;
  logic          adv1, accept;

  assign adv1          = s1_valid_q && (!s1_prod_q || !out_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || adv1;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // column and row counting at acceptance
  logic [AW-1:0] col_q, col_d, col_cur;
  logic [15:0]   row_q, row_d, row_cur;
  logic          last0, prod0;
  pixel_t        cur0;

  assign cur0 = {s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tdata[23:16]};

  always_comb begin
    col_cur = s_axis_tuser ? '0 : col_q;
    row_cur = s_axis_tuser ? 16'd0 : row_q;
    last0   = (EW'(col_cur) + EW'(1)) >= width_eff;
    prod0   = (EW'(col_cur) >= EW'(2)) && (row_cur >= 16'd2);
    col_d   = col_q;
    row_d   = row_q;
    if (accept) begin
      if (last0) begin
        col_d = '0;
        row_d = (row_cur != 16'hFFFF) ? row_cur + 16'd1 : row_cur;
      end else begin
        col_d = col_cur + AW'(1);
        row_d = row_cur;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= 16'd0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // line store: upper row in the high half, middle row in the low half
  logic [47:0] line_mem [MAX_WIDTH];
  logic [47:0] mem_rd_q, fwd_data_q;
  logic        fwd_q;
  pixel_t      lines_up, lines_mid;

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      line_mem[s1_addr_q] <= {lines_mid, s1_cur_q};
    end
    if (accept) begin
      mem_rd_q <= line_mem[col_cur];
    end
    if (accept) begin
      fwd_data_q <= {lines_mid, s1_cur_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (accept) begin
      // written back at this same edge, so the memory read returns stale data
      fwd_q <= adv1 && (s1_addr_q == col_cur);
    end
  end

  assign lines_up  = fwd_q ? fwd_data_q[47:24] : mem_rd_q[47:24];
  assign lines_mid = fwd_q ? fwd_data_q[23:0]  : mem_rd_q[23:0];

  // stage 1 registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (adv1) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_addr_q <= col_cur;
      s1_cur_q  <= cur0;
      s1_prod_q <= prod0;
      s1_last_q <= last0;
    end
  end

  // window columns: age 1 and age 2, rows cur, mid, up
  pixel_t win1_q [3];
  pixel_t win2_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < 3; a++) begin
        win1_q[a] <= '0;
        win2_q[a] <= '0;
      end
    end else if (adv1) begin
      win2_q    <= win1_q;
      win1_q[0] <= s1_cur_q;
      win1_q[1] <= lines_mid;
      win1_q[2] <= lines_up;
    end
  end

  // kernel datapath
  pixel_t             pix [3][3];
  logic signed [10:0] row_sum [3][3];
  logic signed [10:0] acc [3];
  logic [7:0]         res [3];
  logic [7:0]         chan;

  always_comb begin
    pix[0][0] = s1_cur_q;
    pix[1][0] = lines_mid;
    pix[2][0] = lines_up;
    for (int a = 0; a < 3; a++) begin
      pix[a][1] = win1_q[a];
      pix[a][2] = win2_q[a];
    end
    chan = 8'd0;
    for (int ch = 0; ch < 3; ch++) begin
      for (int a = 0; a < 3; a++) begin
        row_sum[ch][a] = 11'sd0;
        for (int b = 0; b < 3; b++) begin
          chan = pix[a][b][23 - 8 * ch -: 8];
          if (EMB_KERNEL[kernel_sel_q][a * 3 + b] == 2'sd1) begin
            row_sum[ch][a] = row_sum[ch][a] + $signed({3'b000, chan});
          end else if (EMB_KERNEL[kernel_sel_q][a * 3 + b] == -2'sd1) begin
            row_sum[ch][a] = row_sum[ch][a] - $signed({3'b000, chan});
          end
        end
      end
      acc[ch] = row_sum[ch][0] + row_sum[ch][1] + row_sum[ch][2];
      if (acc[ch] < 11'sd0) begin
        res[ch] = 8'd0;
      end else if (acc[ch] > 11'sd255) begin
        res[ch] = 8'd255;
      end else begin
        res[ch] = acc[ch][7:0];
      end
    end
  end

  // output register
  logic        load_out;
  logic [23:0] out_data_q;
  logic        out_last_q;

  assign load_out = adv1 && s1_prod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_data_q <= {res[2], res[1], res[0]};
      out_last_q <= s1_last_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

endmodule

/* tb/sv/emb3_emboss_checker.sv */
`timescale 1ns / 100ps
// checker for the 3x3 emboss convolution core: keeps its own line stores and window,
// predicts each filtered pixel from the accepted input words and compares result words
// depends on emb3_pkg for the register indexes and the pixel type
module emb3_emboss_checker
  import emb3_pkg::*;
#(
  parameter int MAX_W = 2048
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [11:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,
  input  logic        s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [23:0] m_axis_tdata,
  input  logic        m_axis_tlast,
  output int          mismatches_o,
  output int          pending_o,
  output int          checked_o
);

  typedef struct packed {
    logic       row_end;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } filt_px_t;

  localparam logic [11:0] WIDTH_AT_RESET = 12'd642;

  // tap a*3+b weights the pixel of row age a, column age b (newest pixel is tap 0)
  localparam int EMBOSS_TAPS [8][9] = '{
    '{-1, 0,  0, 0, 0, 0,  0, 0,  1},
    '{ 1, 0,  0, 0, 0, 0,  0, 0, -1},
    '{ 0, 0, -1, 0, 0, 0,  1, 0,  0},
    '{ 0, 0,  1, 0, 0, 0, -1, 0,  0},
    '{-1, 0, -1, 0, 0, 0,  1, 0,  1},
    '{-1, 0,  1, 0, 0, 0,  1, 0, -1},
    '{ 1, 0,  1, 0, 0, 0, -1, 0, -1},
    '{ 1, 0, -1, 0, 0, 0, -1, 0,  1}
  };

  logic [2:0]  kernel_sel;
  logic [11:0] width_cfg;
  pixel_t      line_upper [MAX_W];
  pixel_t      line_middle [MAX_W];
  pixel_t      col_age1 [3];
  pixel_t      col_age2 [3];
  int unsigned col_cnt;
  int unsigned row_cnt;
  filt_px_t    expected_pixels [$];
  int          bad_results;
  int          good_results;

  always @(posedge clk_i or negedge rst_ni) begin
    filt_px_t    got;
    filt_px_t    want;
    filt_px_t    res;
    pixel_t      cur;
    pixel_t      up;
    pixel_t      mid;
    pixel_t      win [3][3];
    logic [7:0]  chan [3];
    int unsigned eff_w;
    int unsigned slot;
    int          acc;

    if (!rst_ni) begin
      kernel_sel = '0;
      width_cfg  = WIDTH_AT_RESET;
      col_cnt    = 0;
      row_cnt    = 0;
      for (int i = 0; i < 3; i++) begin
        col_age1[i] = '0;
        col_age2[i] = '0;
      end
      expected_pixels.delete();
      bad_results  = 0;
      good_results = 0;
      mismatches_o <= 0;
      pending_o    <= 0;
      checked_o    <= 0;
    end else begin
      // a result leaving now belongs to an earlier pixel, so compare before predicting
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tlast, m_axis_tdata};
        if (expected_pixels.size() == 0) begin
          bad_results++;
          if (bad_results <= 10)
            $display("[%0t] result word r=%0d g=%0d b=%0d last=%0b with none outstanding",
                     $realtime, got.red, got.green, got.blue, got.row_end);
        end else begin
          want = expected_pixels.pop_front();
          if (got.red !== want.red || got.green !== want.green ||
              got.blue !== want.blue || got.row_end !== want.row_end) begin
            bad_results++;
            if (bad_results <= 10)
              $display("[%0t] result word differs: expected r=%0d g=%0d b=%0d last=%0b, %s",
                       $realtime, want.red, want.green, want.blue, want.row_end,
                       $sformatf("got r=%0d g=%0d b=%0d last=%0b",
                                 got.red, got.green, got.blue, got.row_end));
          end else begin
            good_results++;
          end
        end
      end

      if (s_axis_tvalid && s_axis_tready) begin
        eff_w = (width_cfg < 12'd3) ? 3 : (width_cfg > MAX_W) ? MAX_W : width_cfg;
        cur   = s_axis_tdata;
        if (s_axis_tuser) begin
          col_cnt = 0;
          row_cnt = 0;
        end
        slot = (col_cnt >= MAX_W) ? 0 : col_cnt;
        up   = line_upper[slot];
        mid  = line_middle[slot];
        line_upper[slot]  = mid;
        line_middle[slot] = cur;

        win[0][0] = cur;
        win[1][0] = mid;
        win[2][0] = up;
        for (int a = 0; a < 3; a++) begin
          win[a][1] = col_age1[a];
          win[a][2] = col_age2[a];
        end

        if (col_cnt >= 2 && row_cnt >= 2) begin
          // channel 0 is red, in the low byte of the word
          for (int ch = 0; ch < 3; ch++) begin
            acc = 0;
            for (int a = 0; a < 3; a++)
              for (int b = 0; b < 3; b++)
                acc += EMBOSS_TAPS[kernel_sel][a*3 + b] * int'(win[a][b][8*ch +: 8]);
            chan[ch] = (acc > 255) ? 8'hFF : (acc < 0) ? 8'h00 : 8'(acc);
          end
          res.red     = chan[0];
          res.green   = chan[1];
          res.blue    = chan[2];
          res.row_end = (col_cnt + 1 >= eff_w);
          expected_pixels.push_back(res);
        end

        for (int a = 0; a < 3; a++) col_age2[a] = col_age1[a];
        col_age1[0] = cur;
        col_age1[1] = mid;
        col_age1[2] = up;

        if (col_cnt + 1 >= eff_w) begin
          col_cnt = 0;
          if (row_cnt < 32'hFFFF) row_cnt++;
        end else begin
          col_cnt++;
        end
      end

      if (cfg_we_i) begin
        if (cfg_idx_i == REG_KERNEL_SELECT) kernel_sel = cfg_wdata_i[2:0];
        else width_cfg = cfg_wdata_i;
      end

      mismatches_o <= bad_results;
      checked_o    <= good_results;
      pending_o    <= expected_pixels.size();
    end
  end

endmodule

/* tb/sv/tb_emboss_3x3_convolution_core.sv */
`timescale 1ns / 100ps
// top of the emboss core testbench: clock, reset, pixel stream and register writes
// depends on emb3_pkg, emboss_3x3_convolution_core and emb3_emboss_checker
module tb_emboss_3x3_convolution_core;
  import emb3_pkg::*;

  localparam int MAX_W       = 2048;
  localparam int HOLD_CYCLES = 300;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic        cfg_idx_i     = REG_KERNEL_SELECT;
  logic [11:0] cfg_wdata_i   = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // fields from bit 0: pixel_red, pixel_green, pixel_blue
  logic [23:0] s_axis_tdata  = '0;
  // fields from bit 0: start_of_frame
  logic        s_axis_tuser  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // fields from bit 0: out_red, out_green, out_blue
  logic [23:0] m_axis_tdata;
  logic        m_axis_tlast;

  int mismatches;
  int pending;
  int checked;
  int pixels_sent = 0;

  logic steady    = 1'b0;
  logic hold_go   = 1'b0;
  logic hold_done = 1'b0;
  int   hold_left = 0;

  emboss_3x3_convolution_core #(
    .MAX_WIDTH(MAX_W)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  emb3_emboss_checker #(
    .MAX_W(MAX_W)
  ) emboss_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .mismatches_o (mismatches),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // receiver: random back-pressure, one long hold-off on request
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else if (hold_go && !hold_done) begin
      m_axis_tready <= 1'b0;
      hold_left     <= HOLD_CYCLES;
      hold_done     <= 1'b1;
    end else begin
      m_axis_tready <= steady || ($urandom_range(99) >= 32);
    end
  end

  // n pixels; extreme_pct is the chance of a channel being 0 or 255
  task automatic send_run(input int n, input logic first_sof, input logic noisy_sof,
                          input int extreme_pct);
    pixel_t px;
    logic   sof;
    for (int i = 0; i < n; i++) begin
      sof = (i == 0) ? first_sof : (noisy_sof && $urandom_range(199) == 0);
      for (int ch = 0; ch < 3; ch++)
        px[8*ch +: 8] = ($urandom_range(99) < extreme_pct) ?
                        ($urandom_range(1) ? 8'hFF : 8'h00) : 8'($urandom_range(255));
      while (!steady && $urandom_range(99) < 32) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
      end
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= px;
      s_axis_tuser  <= sof;
      @(posedge clk_i);
      while (!s_axis_tready) @(posedge clk_i);
      pixels_sent++;
    end
  endtask

  // stop offering words and let every outstanding result drain
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [11:0] value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    int          phase;
    int          run_len;
    int          pick;
    logic [11:0] new_width;
    logic        width_changed;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset values: kernel 0 and a 642-pixel row, offered with no idling
    steady <= 1'b1;
    send_run(2 * 642 + 12, 1'b1, 1'b0, 20);
    steady <= 1'b0;
    settle();

    // shrink the width mid-row: the current column is already past the new width
    write_reg(REG_PADDED_WIDTH, 12'd10);
    send_run(40, 1'b0, 1'b0, 10);
    settle();

    // width 0 acts as 3; two rows, then one row of extremes per kernel
    write_reg(REG_PADDED_WIDTH, 12'd0);
    write_reg(REG_KERNEL_SELECT, 12'd0);
    send_run(6, 1'b1, 1'b0, 100);
    for (int k = 0; k < 8; k++) begin
      settle();
      write_reg(REG_KERNEL_SELECT, 12'(k));
      send_run(3, 1'b0, 1'b0, 100);
    end
    settle();

    phase = 0;
    while (pixels_sent < 1650) begin
      write_reg(REG_KERNEL_SELECT, 12'($urandom_range(7)));
      width_changed = 1'b0;
      run_len       = $urandom_range(20, 80);
      if (phase == 2) begin
        // the long output hold-off lands in this run while words keep coming
        hold_go <= 1'b1;
        run_len = 120;
      end else if ($urandom_range(1) == 1) begin
        pick = $urandom_range(99);
        if (pick < 12) new_width = 12'($urandom_range(2));
        else if (pick < 85) new_width = 12'($urandom_range(3, 12));
        else new_width = 12'($urandom_range(13, 40));
        write_reg(REG_PADDED_WIDTH, new_width);
        width_changed = 1'b1;
      end
      send_run(run_len, width_changed || ($urandom_range(9) == 0), 1'b1, 20);
      phase++;
      settle();
    end

    repeat (16) @(posedge clk_i);
    $display("covered %0d input words and %0d checked results over all eight kernels,",
             pixels_sent, checked);
    $display("the reset width, widths 0 to 40, a mid-row shrink and a long output stall");
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("timed out with %0d results outstanding", pending);
    $display("== FAIL ==");
    $finish;
  end

endmodule
